// File: rtl/core/adsr_pkg.sv
// Shared constants and types for the ADSR tone voice.
// Used by adsr_div, adsr_envelope_tone_voice_unit and the bench; depends on nothing.
package adsr_pkg;

  localparam int unsigned PhaseBitsDefault = 32;
  localparam int unsigned SineDepthDefault = 256;

  // Field widths
  localparam int unsigned CmdW    = 3;
  localparam int unsigned ShapeW  = 3;
  localparam int unsigned MsW     = 16;
  localparam int unsigned LevelW  = 17;
  localparam int unsigned SampleW = 16;
  localparam int unsigned AddrW   = 5;

  // Shared divider: 33-bit dividend, 16-bit divisor, one quotient bit per cycle
  localparam int unsigned DivNumW = 33;
  localparam int unsigned DivDenW = 16;

  // Shared multiplier operands
  localparam int unsigned MulAW = 33;
  localparam int unsigned MulBW = 24;
  localparam int unsigned MulPW = MulAW + MulBW;

  // Commands
  localparam logic [CmdW-1:0] CMD_SAMPLE = 3'd0;
  localparam logic [CmdW-1:0] CMD_MSTICK = 3'd1;
  localparam logic [CmdW-1:0] CMD_START  = 3'd2;
  localparam logic [CmdW-1:0] CMD_STOP   = 3'd3;
  localparam logic [CmdW-1:0] CMD_PLAY   = 3'd4;

  // Wave shapes
  localparam logic [ShapeW-1:0] SHAPE_SINE   = 3'd0;
  localparam logic [ShapeW-1:0] SHAPE_SQUARE = 3'd1;
  localparam logic [ShapeW-1:0] SHAPE_TRI    = 3'd2;
  localparam logic [ShapeW-1:0] SHAPE_SAW    = 3'd3;
  localparam logic [ShapeW-1:0] SHAPE_NOISE  = 3'd4;

  // Register indexes
  localparam logic [2:0] REG_SHAPE   = 3'd0;
  localparam logic [2:0] REG_PINC    = 3'd1;
  localparam logic [2:0] REG_ATTACK  = 3'd2;
  localparam logic [2:0] REG_DECAY   = 3'd3;
  localparam logic [2:0] REG_SUSTAIN = 3'd4;
  localparam logic [2:0] REG_RELEASE = 3'd5;
  localparam logic [2:0] REG_GAIN    = 3'd6;

  // Register reset values
  localparam logic [MsW-1:0]    ATTACK_RST  = 16'd10;
  localparam logic [MsW-1:0]    RELEASE_RST = 16'd10;
  localparam logic [LevelW-1:0] SUSTAIN_RST = 17'd65536;
  localparam logic [LevelW-1:0] GAIN_RST    = 17'd32768;

  localparam logic [LevelW-1:0] ONE_Q16  = 17'd65536;
  localparam logic [15:0]       LFSR_SEED = 16'hACE1;
  localparam logic [15:0]       LFSR_TAPS = 16'hB400;

  // Quarter-wave sine polynomial coefficients, Q16
  localparam logic [16:0] SIN_A = 17'd102944;
  localparam logic [15:0] SIN_B = 16'd42334;
  localparam logic [12:0] SIN_C = 13'd4926;
  localparam logic [7:0]  AMP_K = 8'd181;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: rtl/core/adsr_div.sv
// Restoring divider shared by the envelope ramps and the noise modulo.
// One quotient bit per cycle; depends on adsr_pkg.
module adsr_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [adsr_pkg::DivNumW-1:0]  num_i,
  input  logic [adsr_pkg::DivDenW-1:0]  den_i,
  output adsr_pkg::div_stat_t           stat_o,
  output logic [adsr_pkg::DivNumW-1:0]  quot_o,
  output logic [adsr_pkg::DivDenW-1:0]  rem_o
);
  import adsr_pkg::*;

  localparam int unsigned CntW = $clog2(DivNumW + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [DivNumW-1:0] quot_q, quot_d;
  logic [DivDenW-1:0] rem_q, rem_d;
  logic [DivDenW-1:0] den_q, den_d;
  logic [DivDenW:0]   trial;
  logic               fits;

  assign trial = {rem_q, quot_q[DivNumW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DivNumW);
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d  = fits ? DivDenW'(trial - {1'b0, den_q}) : trial[DivDenW-1:0];
      quot_d = {quot_q[DivNumW-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;
  assign rem_o       = rem_q;

endmodule

// File: rtl/core/adsr_envelope_tone_voice_unit.sv
// Single synthesizer voice: ADSR envelope, five wave shapes, noise LFSR.
// Top level; depends on adsr_pkg and adsr_div.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_ready_o   | command_i, duration_ms_i
//  out     | output    | out_valid_o/out_ready_i | sample_o, sounding_o
//  apb     | input     | psel/penable, pready=1  | paddr, pwrite, pwdata, prdata
//
// Start, stop, play-for and ms ticks finish in the idle state; a sample tick with
// the voice off or a zero phase step goes from idle straight to the done state. A
// sounding sample tick runs the envelope, amplitude and wave states, and an envelope
// ramp or the noise modulo also waits on a run of the serial divider.
// in_ready_o is high only while the sequencer is idle; a finished transaction
// waits in the output register and the sequencer holds until it drains.
// Reset is asynchronous and clears all control state; no clearing pass.
module adsr_envelope_tone_voice_unit #(
  parameter int unsigned PHASE_BITS       = adsr_pkg::PhaseBitsDefault,
  parameter int unsigned SINE_TABLE_DEPTH = adsr_pkg::SineDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [adsr_pkg::CmdW-1:0]     command_i,
  input  logic [31:0]                   duration_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [adsr_pkg::SampleW-1:0] sample_o,
  output logic                          sounding_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [adsr_pkg::AddrW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import adsr_pkg::*;

  localparam int unsigned IdxW = $clog2(SINE_TABLE_DEPTH);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_ENV   = 5'd1;
  localparam logic [4:0] ST_EDIV  = 5'd2;
  localparam logic [4:0] ST_EWAIT = 5'd3;
  localparam logic [4:0] ST_AMP1  = 5'd4;
  localparam logic [4:0] ST_AMP2  = 5'd5;
  localparam logic [4:0] ST_AMP3  = 5'd6;
  localparam logic [4:0] ST_AMP4  = 5'd7;
  localparam logic [4:0] ST_WAVE  = 5'd8;
  localparam logic [4:0] ST_SIN2  = 5'd9;
  localparam logic [4:0] ST_SIN3  = 5'd10;
  localparam logic [4:0] ST_SIN4  = 5'd11;
  localparam logic [4:0] ST_SIN5  = 5'd12;
  localparam logic [4:0] ST_SCALE = 5'd13;
  localparam logic [4:0] ST_NWAIT = 5'd14;
  localparam logic [4:0] ST_DONE  = 5'd15;

  localparam logic [1:0] EM_ATK = 2'd0;
  localparam logic [1:0] EM_DEC = 2'd1;
  localparam logic [1:0] EM_REL = 2'd2;

  localparam logic [1:0] SH_16 = 2'd0;
  localparam logic [1:0] SH_30 = 2'd1;
  localparam logic [1:0] SH_31 = 2'd2;

  // Configuration registers
  logic [ShapeW-1:0] shape_q;
  logic [31:0]       pinc_q;
  logic [MsW-1:0]    attack_q, decay_q, release_q;
  logic [LevelW-1:0] sustain_q, gain_q;

  // Voice state
  logic [4:0]            state_q, state_d;
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [31:0]           elapsed_q, elapsed_d;
  logic [31:0]           stop_at_q, stop_at_d;
  logic                  armed_q, armed_d;
  logic                  playing_q, playing_d;
  logic [15:0]           lfsr_q, lfsr_d;
  logic                  out_valid_q, out_valid_d;
  logic [SampleW-1:0]    sample_q, sample_d;
  logic                  sounding_q, sounding_d;

  // Work registers
  logic [1:0]         emode_q, emode_d;
  logic [LevelW-1:0]  env_q, env_d;
  logic [15:0]        amp_q, amp_d;
  logic [16:0]        xs_q, xs_d;
  logic [16:0]        x2_q, x2_d;
  logic               neg_q, neg_d;
  logic [1:0]         sh_q, sh_d;
  logic [SampleW-1:0] res_q, res_d;
  logic               on_q, on_d;
  logic [MulPW-1:0]   mul_q;
  logic [MulAW-1:0]   mul_a;
  logic [MulBW-1:0]   mul_b;

  // Divider
  logic               div_start;
  logic [DivNumW-1:0] div_num;
  logic [DivDenW-1:0] div_den;
  div_stat_t          div_stat;
  logic [DivNumW-1:0] div_quot;
  logic [DivDenW-1:0] div_rem;

  adsr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .stat_o (div_stat),
    .quot_o (div_quot),
    .rem_o  (div_rem)
  );

  // Envelope decisions
  logic [LevelW-1:0] sus, gain;
  logic [31:0]       s_rel;
  logic              rel_act, rel_end, in_atk, in_dec;
  logic [16:0]       ad_sum;
  logic [17:0]       adr_sum;
  logic [32:0]       e_plus10;
  logic [31:0]       len_play;

  assign sus      = (sustain_q > ONE_Q16) ? ONE_Q16 : sustain_q;
  assign gain     = (gain_q > ONE_Q16) ? ONE_Q16 : gain_q;
  assign rel_act  = armed_q && (elapsed_q > stop_at_q);
  assign s_rel    = elapsed_q - stop_at_q;
  assign rel_end  = s_rel >= {16'd0, release_q};
  assign in_atk   = elapsed_q < {16'd0, attack_q};
  assign ad_sum   = {1'b0, attack_q} + {1'b0, decay_q};
  assign adr_sum  = {1'b0, ad_sum} + {2'b0, release_q};
  assign in_dec   = (decay_q != '0) && (sus < ONE_Q16) && (elapsed_q < {15'd0, ad_sum});
  assign e_plus10 = {1'b0, elapsed_q} + 33'd10;
  assign len_play = (duration_ms_i > {14'd0, adr_sum}) ? duration_ms_i : {14'd0, adr_sum};

  // Phase views
  logic [31:0]     p32;
  logic [IdxW-1:0] kidx;
  logic [1:0]      quad;
  logic [16:0]     xr, xs;
  logic [32:0]     tri_m, saw_m;
  logic            tri_neg, saw_neg;

  assign p32  = 32'(phase_q) << (32 - PHASE_BITS);
  assign kidx = p32[31 -: IdxW];
  assign quad = kidx[IdxW-1 -: 2];
  assign xr   = 17'(kidx[IdxW-3:0]) << (18 - IdxW);
  assign xs   = quad[0] ? (ONE_Q16 - xr) : xr;

  always_comb begin
    if (p32[31:30] == 2'b00) begin
      tri_m   = {1'b0, p32};
      tri_neg = 1'b0;
    end else if (p32 <= 32'h8000_0000) begin
      tri_m   = 33'h0_8000_0000 - {1'b0, p32};
      tri_neg = 1'b0;
    end else if (p32 < 32'hC000_0000) begin
      tri_m   = {1'b0, p32} - 33'h0_8000_0000;
      tri_neg = 1'b1;
    end else begin
      tri_m   = 33'h1_0000_0000 - {1'b0, p32};
      tri_neg = 1'b1;
    end
  end

  assign saw_neg = p32[31];
  assign saw_m   = saw_neg ? (33'h1_0000_0000 - {1'b0, p32}) : {1'b0, p32};

  logic [15:0] lfsr_step;
  assign lfsr_step = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);

  // Sine polynomial intermediates taken from the multiplier register
  logic [16:0] t_val, u_val, y_val;
  logic [18:0] y_raw;
  assign t_val = 17'(SIN_B) - mul_q[32:16];
  assign u_val = SIN_A - mul_q[32:16];
  assign y_raw = mul_q[34:16];
  assign y_val = (y_raw > 19'(ONE_Q16)) ? ONE_Q16 : y_raw[16:0];

  logic [SampleW-1:0] scale_v;
  always_comb begin
    case (sh_q)
      SH_30:   scale_v = mul_q[45:30];
      SH_31:   scale_v = mul_q[46:31];
      default: scale_v = mul_q[31:16];
    endcase
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_ENV: begin
        if (rel_act) begin
          mul_a = MulAW'(s_rel[15:0]);
          mul_b = MulBW'(sus);
        end else begin
          mul_a = MulAW'(16'(elapsed_q - {16'd0, attack_q}));
          mul_b = MulBW'(ONE_Q16 - sus);
        end
      end
      ST_AMP1: begin
        mul_a = MulAW'(gain);
        mul_b = MulBW'(env_q);
      end
      ST_AMP2: begin
        mul_a = mul_q[32:0];
        mul_b = MulBW'(AMP_K);
      end
      ST_AMP3: begin
        mul_a = MulAW'(mul_q[39:16]);
        mul_b = mul_q[39:16];
      end
      ST_WAVE: begin
        case (shape_q)
          SHAPE_SINE: begin
            mul_a = MulAW'(xs);
            mul_b = MulBW'(xs);
          end
          SHAPE_TRI: begin
            mul_a = tri_m;
            mul_b = MulBW'(amp_q);
          end
          SHAPE_SAW: begin
            mul_a = saw_m;
            mul_b = MulBW'(amp_q);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      ST_SIN2: begin
        mul_a = MulAW'(SIN_C);
        mul_b = MulBW'(mul_q[32:16]);
      end
      ST_SIN3: begin
        mul_a = MulAW'(x2_q);
        mul_b = MulBW'(t_val);
      end
      ST_SIN4: begin
        mul_a = MulAW'(xs_q);
        mul_b = MulBW'(u_val);
      end
      ST_SIN5: begin
        mul_a = MulAW'(y_val);
        mul_b = MulBW'(amp_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    elapsed_d   = elapsed_q;
    stop_at_d   = stop_at_q;
    armed_d     = armed_q;
    playing_d   = playing_q;
    lfsr_d      = lfsr_q;
    out_valid_d = out_valid_q;
    sample_d    = sample_q;
    sounding_d  = sounding_q;
    emode_d     = emode_q;
    env_d       = env_q;
    amp_d       = amp_q;
    xs_d        = xs_q;
    x2_d        = x2_q;
    neg_d       = neg_q;
    sh_d        = sh_q;
    res_d       = res_q;
    on_d        = on_q;
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = '0;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (command_i)
            CMD_SAMPLE: begin
              if (playing_q && (pinc_q != '0)) begin
                on_d    = 1'b1;
                state_d = ST_ENV;
              end else begin
                on_d    = 1'b0;
                res_d   = '0;
                state_d = ST_DONE;
              end
            end
            CMD_MSTICK: begin
              if (playing_q && (elapsed_q != 32'hFFFF_FFFF)) elapsed_d = elapsed_q + 32'd1;
            end
            CMD_START: begin
              playing_d = 1'b1;
              elapsed_d = '0;
              armed_d   = 1'b0;
              stop_at_d = '0;
              phase_d   = '0;
            end
            CMD_STOP: begin
              if (playing_q) begin
                if (elapsed_q > {15'd0, ad_sum}) begin
                  stop_at_d = e_plus10[32] ? 32'hFFFF_FFFF : e_plus10[31:0];
                end else begin
                  stop_at_d = {15'd0, ad_sum};
                end
                armed_d = 1'b1;
              end
            end
            CMD_PLAY: begin
              playing_d = 1'b1;
              elapsed_d = '0;
              stop_at_d = len_play;
              armed_d   = 1'b1;
              phase_d   = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ENV: begin
        if (rel_act && rel_end) begin
          // release ran out: end the voice, this sample comes out zero
          playing_d = 1'b0;
          armed_d   = 1'b0;
          stop_at_d = '0;
          env_d     = '0;
          state_d   = ST_AMP1;
        end else if (rel_act) begin
          emode_d = EM_REL;
          state_d = ST_EDIV;
        end else if (in_atk) begin
          emode_d = EM_ATK;
          state_d = ST_EDIV;
        end else if (in_dec) begin
          emode_d = EM_DEC;
          state_d = ST_EDIV;
        end else begin
          env_d   = sus;
          state_d = ST_AMP1;
        end
      end
      ST_EDIV: begin
        div_start = 1'b1;
        case (emode_q)
          EM_ATK: begin
            div_num = {1'b0, elapsed_q[15:0], 16'd0};
            div_den = attack_q;
          end
          EM_DEC: begin
            div_num = mul_q[DivNumW-1:0];
            div_den = decay_q;
          end
          default: begin
            div_num = mul_q[DivNumW-1:0];
            div_den = release_q;
          end
        endcase
        state_d = ST_EWAIT;
      end
      ST_EWAIT: begin
        if (div_stat.done) begin
          case (emode_q)
            EM_ATK:  env_d = div_quot[LevelW-1:0];
            EM_DEC:  env_d = ONE_Q16 - div_quot[LevelW-1:0];
            default: env_d = sus - div_quot[LevelW-1:0];
          endcase
          state_d = ST_AMP1;
        end
      end
      ST_AMP1: state_d = ST_AMP2;
      ST_AMP2: state_d = ST_AMP3;
      ST_AMP3: state_d = ST_AMP4;
      ST_AMP4: begin
        amp_d   = mul_q[47:32];
        state_d = ST_WAVE;
      end
      ST_WAVE: begin
        // sample uses the phase before this step
        phase_d = phase_q + pinc_q[31 -: PHASE_BITS];
        case (shape_q)
          SHAPE_SINE: begin
            xs_d    = xs;
            neg_d   = quad[1];
            sh_d    = SH_16;
            state_d = ST_SIN2;
          end
          SHAPE_SQUARE: begin
            res_d   = (p32 > 32'h8000_0000) ? (16'd0 - amp_q) : amp_q;
            state_d = ST_DONE;
          end
          SHAPE_TRI: begin
            neg_d   = tri_neg;
            sh_d    = SH_30;
            state_d = ST_SCALE;
          end
          SHAPE_SAW: begin
            neg_d   = saw_neg;
            sh_d    = SH_31;
            state_d = ST_SCALE;
          end
          SHAPE_NOISE: begin
            lfsr_d = lfsr_step;
            if (amp_q == '0) begin
              res_d   = '0;
              state_d = ST_DONE;
            end else begin
              div_start = 1'b1;
              div_num   = DivNumW'(lfsr_step);
              div_den   = DivDenW'({amp_q, 1'b0});
              state_d   = ST_NWAIT;
            end
          end
          default: begin
            res_d   = '0;
            state_d = ST_DONE;
          end
        endcase
      end
      ST_SIN2: begin
        x2_d    = mul_q[32:16];
        state_d = ST_SIN3;
      end
      ST_SIN3: state_d = ST_SIN4;
      ST_SIN4: state_d = ST_SIN5;
      ST_SIN5: state_d = ST_SCALE;
      ST_SCALE: begin
        res_d   = neg_q ? (16'd0 - scale_v) : scale_v;
        state_d = ST_DONE;
      end
      ST_NWAIT: begin
        if (div_stat.done) begin
          res_d   = div_rem - amp_q;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          sample_d    = res_q;
          sounding_d  = on_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= '0;
      elapsed_q   <= '0;
      stop_at_q   <= '0;
      armed_q     <= 1'b0;
      playing_q   <= 1'b0;
      lfsr_q      <= LFSR_SEED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      elapsed_q   <= elapsed_d;
      stop_at_q   <= stop_at_d;
      armed_q     <= armed_d;
      playing_q   <= playing_d;
      lfsr_q      <= lfsr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q   <= sample_d;
    sounding_q <= sounding_d;
    emode_q    <= emode_d;
    env_q      <= env_d;
    amp_q      <= amp_d;
    xs_q       <= xs_d;
    x2_q       <= x2_d;
    neg_q      <= neg_d;
    sh_q       <= sh_d;
    res_q      <= res_d;
    on_q       <= on_d;
  end

  // Configuration port
  logic       cfg_we;
  logic [2:0] cfg_idx;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[AddrW-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q   <= SHAPE_SINE;
      pinc_q    <= '0;
      attack_q  <= ATTACK_RST;
      decay_q   <= '0;
      sustain_q <= SUSTAIN_RST;
      release_q <= RELEASE_RST;
      gain_q    <= GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SHAPE:   shape_q   <= pwdata[ShapeW-1:0];
        REG_PINC:    pinc_q    <= pwdata;
        REG_ATTACK:  attack_q  <= pwdata[MsW-1:0];
        REG_DECAY:   decay_q   <= pwdata[MsW-1:0];
        REG_SUSTAIN: sustain_q <= pwdata[LevelW-1:0];
        REG_RELEASE: release_q <= pwdata[MsW-1:0];
        REG_GAIN:    gain_q    <= pwdata[LevelW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SHAPE:   prdata = 32'(shape_q);
      REG_PINC:    prdata = pinc_q;
      REG_ATTACK:  prdata = 32'(attack_q);
      REG_DECAY:   prdata = 32'(decay_q);
      REG_SUSTAIN: prdata = 32'(sustain_q);
      REG_RELEASE: prdata = 32'(release_q);
      REG_GAIN:    prdata = 32'(gain_q);
      default:     prdata = '0;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign sounding_o  = sounding_q;

`ifndef SYNTHESIS
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_armed_needs_play: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |-> playing_q)
    else $error("stop armed on an idle voice");

  a_amp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAVE) |-> (amp_q <= 16'd32761))
    else $error("amplitude out of range");

  a_env_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_AMP1) |-> (env_q <= ONE_Q16))
    else $error("envelope above one");

  a_done_waits_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_EWAIT) || (state_q == ST_NWAIT)) && !div_stat.done
      |-> div_stat.busy)
    else $error("waiting on an idle divider");
`endif

endmodule

// File: bench/voice_checker.sv
`timescale 1ns / 1ps
// Checker for the ADSR tone voice: watches the command, sample and APB ports,
// predicts each sample transaction and compares it. Depends on adsr_pkg.
module voice_checker
  import adsr_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [CmdW-1:0]           command_i,
  input  logic [31:0]               duration_ms_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [SampleW-1:0]        sample_i,
  input  logic                      sounding_i,
  input  logic                      psel_i,
  input  logic                      penable_i,
  input  logic                      pwrite_i,
  input  logic                      pready_i,
  input  logic [AddrW-1:0]          paddr_i,
  input  logic [31:0]               pwdata_i,
  output int                        pending_o,
  output int                        failures_o
);

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               sounding;
  } tone_out_t;

  tone_out_t expected_q[$];

  // Register copies
  logic [ShapeW-1:0] shape_r;
  logic [31:0]       pinc_r;
  logic [MsW-1:0]    attack_r, decay_r, release_r;
  logic [LevelW-1:0] sustain_r, gain_r;

  // Voice state
  logic [31:0] phase_r, elapsed_r, stop_at_r;
  logic        armed_r, playing_r;
  logic [15:0] lfsr_r;

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [63:0] quarter_sine(logic [63:0] x);
    logic [63:0] x2, t, u, y;
    x2 = (x * x) >> 16;
    t  = 64'(SIN_B) - ((64'(SIN_C) * x2) >> 16);
    u  = 64'(SIN_A) - ((x2 * t) >> 16);
    y  = (x * u) >> 16;
    return (y > 64'd65536) ? 64'd65536 : y;
  endfunction

  function automatic logic [31:0] scaled(logic neg, logic [63:0] mag, logic [31:0] amp);
    logic [63:0] prod;
    logic [31:0] v;
    prod = mag * 64'(amp);
    v    = prod[63:32];
    return neg ? -v : v;
  endfunction

  // Envelope level, Q1.16; ends the note once the release has run out
  function automatic logic [31:0] envelope_level();
    logic [63:0] e, sus, s, env;
    sus = (sustain_r > ONE_Q16) ? 64'd65536 : 64'(sustain_r);
    e   = 64'(elapsed_r);
    if (e < 64'(attack_r)) begin
      env = (e << 16) / 64'(attack_r);
    end else if (decay_r != 0 && sus < 64'd65536 &&
                 e < 64'(attack_r) + 64'(decay_r)) begin
      env = 64'd65536 - ((e - 64'(attack_r)) * (64'd65536 - sus)) / 64'(decay_r);
    end else begin
      env = sus;
    end
    if (armed_r && elapsed_r > stop_at_r) begin
      s = 64'(elapsed_r - stop_at_r);
      if (s < 64'(release_r)) begin
        env = sus - (s * sus) / 64'(release_r);
      end else begin
        playing_r = 1'b0;
        armed_r   = 1'b0;
        stop_at_r = '0;
        env       = '0;
      end
    end
    return env[31:0];
  endfunction

  function automatic logic [31:0] wave_value(logic [31:0] amp);
    logic [63:0] p, k, q4, quad, rem, x, f;
    logic [15:0] l;
    p = 64'(phase_r);
    case (shape_r)
      SHAPE_SINE: begin
        k    = (p * SineDepthDefault) >> 32;
        q4   = k * 4;
        quad = q4 / SineDepthDefault;
        rem  = q4 - quad * SineDepthDefault;
        x    = (rem << 16) / SineDepthDefault;
        if (quad[0]) x = 64'd65536 - x;
        return scaled(quad[1], quarter_sine(x) << 16, amp);
      end
      SHAPE_SQUARE: return (phase_r > 32'h8000_0000) ? -amp : amp;
      SHAPE_TRI: begin
        if (p < 64'h4000_0000) return scaled(1'b0, p * 4, amp);
        if (p < 64'hC000_0000) begin
          f = p * 4;
          if (f <= 64'h2_0000_0000) return scaled(1'b0, 64'h2_0000_0000 - f, amp);
          return scaled(1'b1, f - 64'h2_0000_0000, amp);
        end
        return scaled(1'b1, 64'h4_0000_0000 - p * 4, amp);
      end
      SHAPE_SAW: begin
        if (p < 64'h8000_0000) return scaled(1'b0, p * 2, amp);
        return scaled(1'b1, 64'h2_0000_0000 - p * 2, amp);
      end
      SHAPE_NOISE: begin
        l = lfsr_r;
        l = l[0] ? ((l >> 1) ^ LFSR_TAPS) : (l >> 1);
        lfsr_r = l;
        if (amp == 0) return '0;
        return (32'(l) % (2 * amp)) - amp;
      end
      default: return '0;
    endcase
  endfunction

  task automatic apply_command(logic [CmdW-1:0] cmd, logic [31:0] dur);
    logic        on;
    logic [31:0] env, s, len;
    logic [63:0] g, x, amp;
    tone_out_t   next_out;
    case (cmd)
      CMD_SAMPLE: begin
        on = playing_r && pinc_r != 0;
        s  = '0;
        if (on) begin
          env = envelope_level();
          g   = (gain_r > ONE_Q16) ? 64'd65536 : 64'(gain_r);
          x   = (g * 64'(env) * 64'd181) >> 16;
          amp = (x * x) >> 32;
          s   = wave_value(amp[31:0]);
          phase_r = phase_r + pinc_r;
        end
        next_out = '{sample: s[SampleW-1:0], sounding: on};
        expected_q.insert(expected_q.size(), next_out);
      end
      CMD_MSTICK: if (playing_r) elapsed_r = sat_add(elapsed_r, 32'd1);
      CMD_START: begin
        playing_r = 1'b1;
        elapsed_r = '0;
        armed_r   = 1'b0;
        stop_at_r = '0;
        phase_r   = '0;
      end
      CMD_STOP: if (playing_r) begin
        stop_at_r = 32'(attack_r) + 32'(decay_r);
        if (elapsed_r > stop_at_r) stop_at_r = sat_add(elapsed_r, 32'd10);
        armed_r = 1'b1;
      end
      CMD_PLAY: begin
        len = 32'(attack_r) + 32'(decay_r) + 32'(release_r);
        if (dur > len) len = dur;
        playing_r = 1'b1;
        elapsed_r = '0;
        stop_at_r = len;
        armed_r   = 1'b1;
        phase_r   = '0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tone_out_t want;
    if (!rst_ni) begin
      shape_r    = '0;
      pinc_r     = '0;
      attack_r   = ATTACK_RST;
      decay_r    = '0;
      sustain_r  = SUSTAIN_RST;
      release_r  = RELEASE_RST;
      gain_r     = GAIN_RST;
      phase_r    = '0;
      elapsed_r  = '0;
      stop_at_r  = '0;
      armed_r    = 1'b0;
      playing_r  = 1'b0;
      lfsr_r     = LFSR_SEED;
      expected_q.delete();
      failures_o <= 0;
      pending_o  <= 0;
    end else begin
      // Check the outgoing transaction before a new command can queue anything
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected sample %0d sounding %0b", $time,
                   $signed(sample_i), sounding_i);
          failures_o <= failures_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.sample !== sample_i || want.sounding !== sounding_i) begin
            $display("%0t: sample expected %0d actual %0d, sounding expected %0b actual %0b",
                     $time, $signed(want.sample), $signed(sample_i),
                     want.sounding, sounding_i);
            failures_o <= failures_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) apply_command(command_i, duration_ms_i);
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[4:2])
          REG_SHAPE:   shape_r   = pwdata_i[ShapeW-1:0];
          REG_PINC:    pinc_r    = pwdata_i;
          REG_ATTACK:  attack_r  = pwdata_i[MsW-1:0];
          REG_DECAY:   decay_r   = pwdata_i[MsW-1:0];
          REG_SUSTAIN: sustain_r = pwdata_i[LevelW-1:0];
          REG_RELEASE: release_r = pwdata_i[MsW-1:0];
          REG_GAIN:    gain_r    = pwdata_i[LevelW-1:0];
          default: ;
        endcase
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Top of the ADSR tone voice bench: clock, reset, command and APB stimulus.
// Depends on adsr_pkg, adsr_envelope_tone_voice_unit and voice_checker.
module tb;
  import adsr_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [CmdW-1:0]    command_i = '0;
  logic [31:0]        duration_ms_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [SampleW-1:0] sample_o;
  logic               sounding_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [AddrW-1:0]   paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  int pending;
  int failures;
  int burst_left = 0;
  int cycle_cnt = 0;

  always #4 clk_i = ~clk_i;

  adsr_envelope_tone_voice_unit DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .command_i, .duration_ms_i,
    .out_valid_o, .out_ready_i, .sample_o, .sounding_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  voice_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .command_i, .duration_ms_i,
    .out_valid_i(out_valid_o), .out_ready_i, .sample_i(sample_o), .sounding_i(sounding_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata), .pending_o(pending), .failures_o(failures)
  );

  // Receiver: cycle through open, random, sparse and alternating stall modes
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    case (cycle_cnt[8:7])
      2'd0: out_ready_i <= 1'b1;
      2'd1: out_ready_i <= 1'($urandom_range(0, 1));
      2'd2: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= cycle_cnt[0];
    endcase
  end

  task automatic send_command(logic [CmdW-1:0] cmd, logic [31:0] dur);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    duration_ms_i <= dur;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_random();
    int          pick;
    logic [31:0] dur;
    pick = $urandom_range(0, 99);
    dur  = $urandom;
    if (pick < 45)      send_command(CMD_SAMPLE, dur);
    else if (pick < 78) send_command(CMD_MSTICK, dur);
    else if (pick < 84) send_command(CMD_START, dur);
    else if (pick < 90) send_command(CMD_STOP, dur);
    else if (pick < 96) begin
      if ($urandom_range(0, 3) != 0) dur = $urandom_range(0, 40);
      send_command(CMD_PLAY, dur);
    end else begin
      send_command(CMD_PLAY + CmdW'($urandom_range(1, 3)), dur);
    end
  endtask

  // Hold until every expected sample is out and the block has settled
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_level();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071) : $urandom_range(0, 65536);
  endfunction

  initial begin
    logic [31:0] pinc;
    logic [31:0] ms_hi;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Idle voice: silent samples, ignored ticks and stops, unknown commands
    send_command(CMD_SAMPLE, 32'h0);
    send_command(CMD_MSTICK, 32'hFFFF_FFFF);
    send_command(CMD_STOP, 32'h0);
    for (int c = CMD_PLAY + 1; c < 8; c++) send_command(CmdW'(c), $urandom);
    send_command(CMD_START, 32'h0);
    send_command(CMD_SAMPLE, 32'h0);
    drain();

    // Extremes: instant ramps, oversized levels, half-cycle phase step
    write_reg(REG_SHAPE, 32'(SHAPE_SQUARE));
    write_reg(REG_PINC, 32'h8000_0000);
    write_reg(REG_ATTACK, 32'h0);
    write_reg(REG_DECAY, 32'h0);
    write_reg(REG_SUSTAIN, 32'h1_FFFF);
    write_reg(REG_RELEASE, 32'h0);
    write_reg(REG_GAIN, 32'h1_FFFF);
    send_command(CMD_START, 32'h0);
    repeat (3) send_command(CMD_SAMPLE, 32'h0);
    send_command(CMD_STOP, 32'h0);
    send_command(CMD_MSTICK, 32'h0);
    send_command(CMD_SAMPLE, 32'h0);   // release runs out here
    send_command(CMD_SAMPLE, 32'h0);
    send_command(CMD_PLAY, 32'hFFFF_FFFF);
    send_command(CMD_SAMPLE, 32'h0);
    send_command(CMD_STOP, 32'h0);
    send_command(CMD_STOP, 32'h0);
    send_command(CMD_MSTICK, 32'h0);
    send_command(CMD_SAMPLE, 32'h0);

    // Random phases, one wave shape each including the unknown ones
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case ($urandom_range(0, 5))
        0: pinc = 32'h0;
        1: pinc = 32'h8000_0000;
        2: pinc = 32'hFFFF_FFFF;
        default: pinc = $urandom_range(1, 32'h1000_0000);
      endcase
      ms_hi = (ph == 3) ? 32'd65535 : 32'd8;
      write_reg(REG_SHAPE, 32'(ph));
      write_reg(REG_PINC, (ph == 1) ? 32'h0123_4567 : pinc);
      write_reg(REG_ATTACK, (ph == 3) ? ms_hi : $urandom_range(0, ms_hi));
      write_reg(REG_DECAY, (ph == 3) ? ms_hi : $urandom_range(0, ms_hi));
      write_reg(REG_SUSTAIN, (ph == 5) ? 32'h0 : pick_level());
      write_reg(REG_RELEASE, (ph == 3) ? ms_hi : $urandom_range(0, ms_hi));
      write_reg(REG_GAIN, (ph == 4) ? 32'd65536 : pick_level());
      send_command(CMD_PLAY, $urandom_range(0, 30));
      repeat (54) send_random();
    end

    drain();
    if (failures == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/adsr_pkg.sv
rtl/core/adsr_div.sv
rtl/core/adsr_envelope_tone_voice_unit.sv
bench/voice_checker.sv
bench/tb.sv
